FILE: rtl/core/shg_pkg.sv
// ============================================================================
// shg_pkg: shared types and constants for the spatial hash grid
// Word formats, command codes, register indexes and the control/status
// bundles between the controller and the datapath.
// ============================================================================
package shg_pkg;

    // table geometry
    localparam int MAX_BUCKETS     = 1024;
    localparam int BUCKET_CAPACITY = 2;
    localparam int ID_BITS         = 16;
    localparam int BKT_W           = $clog2(MAX_BUCKETS);
    localparam int ENT_DEPTH       = MAX_BUCKETS * BUCKET_CAPACITY;
    localparam int ENT_AW          = $clog2(ENT_DEPTH);
    localparam int FILL_W          = 2;

    // coordinate and config widths
    localparam int POS_W   = 32;
    localparam int CS_W    = 31;
    localparam int TS_W    = 11;
    localparam int DIV_CW  = $clog2(POS_W);

    // hash multipliers
    localparam logic [31:0] HASH_KX = 32'd73856093;
    localparam logic [31:0] HASH_KY = 32'd19349663;
    localparam logic [31:0] HASH_KZ = 32'd83492791;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // register indexes
    localparam logic REG_CELL_SIZE  = 1'b0;
    localparam logic REG_TABLE_SIZE = 1'b1;

    // reset values
    localparam logic [CS_W-1:0] CELL_SIZE_RST  = CS_W'(65536);
    localparam logic [TS_W-1:0] TABLE_SIZE_RST = TS_W'(1024);

    // input word
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        particle_id;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [9:0]  bucket;
        logic [15:0] neighbor_id;
        logic        has_neighbor;
        logic        overflow;
        logic        last;
    } t_out_word;

    // kind of result word loaded into the output register
    typedef enum logic [1:0] {
        OK_ACK,
        OK_NEIGH,
        OK_DONE
    } t_okind;

    // controller -> datapath
    typedef struct packed {
        logic   load;
        logic   div_start;
        logic   cell_init;
        logic   center;
        logic   hash_start;
        logic   step_cell;
        logic   fill_rd;
        logic   ent_rd;
        logic   ent_sel;
        logic   ins_wr;
        logic   clr_wr;
        logic   out_load;
        t_okind okind;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic              div_done;
        logic              hash_done;
        logic [1:0]        op;
        logic [FILL_W-1:0] fill;
        logic              last_cell;
        logic              clr_last;
        logic              out_free;
    } t_dp_stat;

endpackage

FILE: rtl/core/shg_div.sv
// ============================================================================
// shg_div: serial floor divider
// Signed 32-bit dividend over unsigned 31-bit divisor, one quotient bit per
// cycle, rounded toward minus infinity.
// ============================================================================
module shg_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [shg_pkg::POS_W-1:0] i_dividend,
    input  logic [shg_pkg::CS_W-1:0]        i_divisor,
    output logic                            o_done,
    output logic [shg_pkg::POS_W-1:0]       o_quot
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [shg_pkg::DIV_CW-1:0]   r_cnt, n_cnt;
    logic [shg_pkg::CS_W-1:0]     r_rem, n_rem;
    logic [shg_pkg::POS_W-1:0]    r_quo, n_quo;
    logic                         r_neg, n_neg;
    logic [shg_pkg::POS_W-1:0]    trial;

    // one restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_neg  = r_neg;
        trial  = {r_rem, r_quo[shg_pkg::POS_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_rem  = '0;
            n_neg  = i_dividend[shg_pkg::POS_W-1];
            n_quo  = i_dividend[shg_pkg::POS_W-1] ? shg_pkg::POS_W'(-i_dividend)
                                                  : i_dividend;
        end else if (r_busy) begin
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = shg_pkg::CS_W'(trial - {1'b0, i_divisor});
                n_quo = {r_quo[shg_pkg::POS_W-2:0], 1'b1};
            end else begin
                n_rem = trial[shg_pkg::CS_W-1:0];
                n_quo = {r_quo[shg_pkg::POS_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == shg_pkg::DIV_CW'(shg_pkg::POS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_neg <= n_neg;
    end

    // floor correction for negative dividends
    assign o_done = r_done;
    assign o_quot = !r_neg ? r_quo : ((r_rem != '0) ? ~r_quo : shg_pkg::POS_W'(-r_quo));

endmodule

FILE: rtl/core/shg_dpath.sv
// ============================================================================
// shg_dpath: spatial hash datapath
// Cell dividers, hash unit with serial modulo, fill and entry memories,
// clearing counter and the output register.
// ============================================================================
module shg_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  shg_pkg::t_in_word             i_data,
    input  logic [shg_pkg::CS_W-1:0]      i_cell_size,
    input  logic [shg_pkg::TS_W-1:0]      i_table_size,
    input  shg_pkg::t_dp_cmd              i_cmd,
    output shg_pkg::t_dp_stat             o_stat,
    input  logic                          i_ready,
    output logic                          o_valid,
    output shg_pkg::t_out_word            o_data
);

    typedef enum logic [2:0] {
        H_IDLE,
        H_ADD,
        H_MUL,
        H_SUM,
        H_MOD
    } t_hph;

    localparam int NIB_N  = 16;
    localparam int NIB_CW = $clog2(NIB_N);

    // item registers
    logic [1:0]                   r_op;
    logic [shg_pkg::ID_BITS-1:0]  r_id;

    // dividers
    logic [shg_pkg::CS_W-1:0]     cs_eff;
    logic                         dx_done, dy_done, dz_done;
    logic [31:0]                  qx, qy, qz;

    // cell coordinates and offsets
    logic [31:0] r_cx, r_cy, r_cz;
    logic [1:0]  r_ox, r_oy, r_oz;

    // hash unit
    t_hph                r_hph;
    logic                r_hdone;
    logic [NIB_CW-1:0]   r_nib;
    logic [31:0]         r_hx, r_hy, r_hz;
    logic [31:0]         r_px, r_py, r_pz;
    logic [31:0]         hsum;
    logic [63:0]         r_hv;
    logic [shg_pkg::BKT_W-1:0] r_rem;
    logic [shg_pkg::TS_W-1:0]  t_eff;
    logic [13:0]         xw;
    logic [13:0]         tk;

    // memories
    logic [shg_pkg::FILL_W-1:0]  r_fill_mem [shg_pkg::MAX_BUCKETS];
    logic [shg_pkg::ID_BITS-1:0] r_ent_mem  [shg_pkg::ENT_DEPTH];
    logic [shg_pkg::FILL_W-1:0]  r_fill_q;
    logic [shg_pkg::ID_BITS-1:0] r_ent_q;
    logic [shg_pkg::BKT_W-1:0]   r_clr;
    logic                        full;
    logic [shg_pkg::ENT_AW-1:0]  ent_base;

    // output register
    logic                        r_out_valid;
    shg_pkg::t_out_word          r_out;
    logic                        out_free;

    assign cs_eff = (i_cell_size == '0) ? shg_pkg::CS_W'(1) : i_cell_size;

    shg_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(i_data.pos_x), .i_divisor(cs_eff), .o_done(dx_done), .o_quot(qx)
    );
    shg_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(i_data.pos_y), .i_divisor(cs_eff), .o_done(dy_done), .o_quot(qy)
    );
    shg_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(i_data.pos_z), .i_divisor(cs_eff), .o_done(dz_done), .o_quot(qz)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_data.cmd;
            r_id <= i_data.particle_id[shg_pkg::ID_BITS-1:0];
        end
    end

    // cell coordinates and neighbor offsets, x outermost
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_init) begin
            r_cx <= qx;
            r_cy <= qy;
            r_cz <= qz;
            r_ox <= i_cmd.center ? 2'd1 : 2'd0;
            r_oy <= i_cmd.center ? 2'd1 : 2'd0;
            r_oz <= i_cmd.center ? 2'd1 : 2'd0;
        end else if (i_cmd.step_cell) begin
            if (r_oz == 2'd2) begin
                r_oz <= 2'd0;
                if (r_oy == 2'd2) begin
                    r_oy <= 2'd0;
                    r_ox <= r_ox + 2'd1;
                end else begin
                    r_oy <= r_oy + 2'd1;
                end
            end else begin
                r_oz <= r_oz + 2'd1;
            end
        end
    end

    // effective modulus
    always_comb begin
        t_eff = i_table_size;
        if (i_table_size == '0) begin
            t_eff = shg_pkg::TS_W'(1);
        end else if (i_table_size > shg_pkg::TS_W'(shg_pkg::MAX_BUCKETS)) begin
            t_eff = shg_pkg::TS_W'(shg_pkg::MAX_BUCKETS);
        end
    end

    // one nibble of the 64-bit hash value per cycle
    always_comb begin
        xw = {4'(0), r_rem} << 4 | 14'(r_hv[63:60]);
        for (int k = 3; k >= 0; k--) begin
            tk = 14'(t_eff) << k;
            if (xw >= tk) begin
                xw = xw - tk;
            end
        end
    end

    // wrapped 32-bit hash sum
    assign hsum = r_px + r_py + r_pz;

    // hash sequence: offset add, multiply, sum, serial modulo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hph   <= H_IDLE;
            r_hdone <= 1'b0;
            r_nib   <= '0;
        end else begin
            case (r_hph)
                H_IDLE: begin
                    if (i_cmd.hash_start) begin
                        r_hph   <= H_ADD;
                        r_hdone <= 1'b0;
                    end
                end
                H_ADD: begin
                    r_hx  <= r_cx + 32'(r_ox) - 32'd1;
                    r_hy  <= r_cy + 32'(r_oy) - 32'd1;
                    r_hz  <= r_cz + 32'(r_oz) - 32'd1;
                    r_hph <= H_MUL;
                end
                H_MUL: begin
                    r_px  <= 32'(r_hx * shg_pkg::HASH_KX);
                    r_py  <= 32'(r_hy * shg_pkg::HASH_KY);
                    r_pz  <= 32'(r_hz * shg_pkg::HASH_KZ);
                    r_hph <= H_SUM;
                end
                H_SUM: begin
                    // sign-extend the wrapped hash to 64 bits
                    r_hv  <= {{32{hsum[31]}}, hsum};
                    r_rem <= '0;
                    r_nib <= '0;
                    r_hph <= H_MOD;
                end
                H_MOD: begin
                    r_hv  <= {r_hv[59:0], 4'd0};
                    r_rem <= shg_pkg::BKT_W'(xw);
                    r_nib <= r_nib + 1'b1;
                    if (r_nib == NIB_CW'(NIB_N - 1)) begin
                        r_hph   <= H_IDLE;
                        r_hdone <= 1'b1;
                    end
                end
                default: r_hph <= H_IDLE;
            endcase
        end
    end

    // fill and entry memories
    assign full     = (r_fill_q >= shg_pkg::FILL_W'(shg_pkg::BUCKET_CAPACITY));
    assign ent_base = shg_pkg::ENT_AW'(r_rem) * shg_pkg::ENT_AW'(shg_pkg::BUCKET_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_fill_mem[r_clr] <= '0;
        end else if (i_cmd.ins_wr && !full) begin
            r_fill_mem[r_rem] <= r_fill_q + 1'b1;
        end
        if (i_cmd.fill_rd) begin
            r_fill_q <= r_fill_mem[r_rem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr && !full) begin
            r_ent_mem[ent_base + shg_pkg::ENT_AW'(r_fill_q)] <= r_id;
        end
        if (i_cmd.ent_rd) begin
            r_ent_q <= r_ent_mem[ent_base + shg_pkg::ENT_AW'(i_cmd.ent_sel)];
        end
    end

    // clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= (r_clr == shg_pkg::BKT_W'(shg_pkg::MAX_BUCKETS - 1)) ? '0
                                                                     : r_clr + 1'b1;
        end
    end

    // output register
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= '0;
            case (i_cmd.okind)
                shg_pkg::OK_ACK: begin
                    r_out.bucket   <= r_rem;
                    r_out.overflow <= full;
                    r_out.last     <= 1'b1;
                end
                shg_pkg::OK_NEIGH: begin
                    r_out.bucket       <= r_rem;
                    r_out.neighbor_id  <= r_ent_q;
                    r_out.has_neighbor <= 1'b1;
                end
                default: begin
                    r_out.last <= 1'b1;
                end
            endcase
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.div_done  = dx_done && dy_done && dz_done;
        o_stat.hash_done = r_hdone;
        o_stat.op        = r_op;
        o_stat.fill      = r_fill_q;
        o_stat.last_cell = (r_ox == 2'd2) && (r_oy == 2'd2) && (r_oz == 2'd2);
        o_stat.clr_last  = (r_clr == shg_pkg::BKT_W'(shg_pkg::MAX_BUCKETS - 1));
        o_stat.out_free  = out_free;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/core/shg_ctrl.sv
// ============================================================================
// shg_ctrl: spatial hash controller
// Sequences clearing, cell division, hashing, memory access and result
// words for each command.
// ============================================================================
module shg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_op,
    output logic                 o_ready,
    input  shg_pkg::t_dp_stat    i_stat,
    output shg_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_HASH,
        S_FILL,
        S_INS,
        S_ENT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_ack, n_clr_ack;
    logic   r_e, n_e;
    logic   two;

    assign two     = (i_stat.fill >= shg_pkg::FILL_W'(2));
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_clr_ack = r_clr_ack;
        n_e       = r_e;
        o_cmd     = '0;
        o_cmd.okind = shg_pkg::OK_DONE;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_clr_ack ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_op == shg_pkg::CMD_INSERT || i_op == shg_pkg::CMD_QUERY) begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end else if (i_op == shg_pkg::CMD_CLEAR) begin
                        n_clr_ack = 1'b1;
                        n_state   = S_CLR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.cell_init  = 1'b1;
                    o_cmd.center     = (i_stat.op == shg_pkg::CMD_INSERT);
                    o_cmd.hash_start = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.fill_rd = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_stat.op == shg_pkg::CMD_INSERT) begin
                    n_state = S_INS;
                end else if (i_stat.fill != '0) begin
                    o_cmd.ent_rd = 1'b1;
                    n_e     = 1'b0;
                    n_state = S_ENT;
                end else if (i_stat.last_cell) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step_cell  = 1'b1;
                    o_cmd.hash_start = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_INS: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.okind    = shg_pkg::OK_ACK;
                    o_cmd.ins_wr   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ENT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.okind    = shg_pkg::OK_NEIGH;
                    if (!r_e && two) begin
                        // second entry of this bucket
                        o_cmd.ent_rd  = 1'b1;
                        o_cmd.ent_sel = 1'b1;
                        n_e = 1'b1;
                    end else if (i_stat.last_cell) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step_cell  = 1'b1;
                        o_cmd.hash_start = 1'b1;
                        n_state = S_HASH;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.okind    = shg_pkg::OK_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_ack <= 1'b0;
            r_e       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_ack <= (n_state == S_CLR) ? n_clr_ack : 1'b0;
            r_e       <= n_e;
        end
    end

endmodule

FILE: rtl/core/spatial_hash_grid_neighbor_table.sv
// ============================================================================
// spatial_hash_grid_neighbor_table: uniform-grid spatial hash
// Inserts particle indexes into bounded hash buckets, lists the contents of
// the 27 surrounding cells on a query, and clears the table.
//
//   channel  dir  handshake              word
//   input    in   i_valid / o_ready      i_data (t_in_word)
//   output   out  o_valid / i_ready      o_data (t_out_word)
//   config   in   psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// Insert: cell division in the serial dividers, the hash with a 16-step
// serial modulo, one fill read, then the entry write with the result load.
// Query: the division, then a hash and a fill read for each of the 27 cells,
// one word per neighbor entry and one for the end marker. Clear: a pass over
// all 1024 fill memory entries, then the marker. Reset starts the same pass;
// no word is accepted until it ends. A stalled output word holds in the
// output register; the controller waits on it before loading the next.
// ============================================================================
module spatial_hash_grid_neighbor_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  shg_pkg::t_in_word     i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output shg_pkg::t_out_word    o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [shg_pkg::CS_W-1:0] r_cell_size;
    logic [shg_pkg::TS_W-1:0] r_table_size;
    shg_pkg::t_dp_cmd         dp_cmd;
    shg_pkg::t_dp_stat        dp_stat;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size  <= shg_pkg::CELL_SIZE_RST;
            r_table_size <= shg_pkg::TABLE_SIZE_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == shg_pkg::REG_CELL_SIZE) begin
                r_cell_size <= pwdata[shg_pkg::CS_W-1:0];
            end else begin
                r_table_size <= pwdata[shg_pkg::TS_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == shg_pkg::REG_TABLE_SIZE) ? 32'(r_table_size)
                                                          : 32'(r_cell_size);

    shg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_op(i_data.cmd),
        .o_ready(o_ready), .i_stat(dp_stat), .o_cmd(dp_cmd)
    );

    shg_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_data(i_data),
        .i_cell_size(r_cell_size), .i_table_size(r_table_size),
        .i_cmd(dp_cmd), .o_stat(dp_stat),
        .i_ready(i_ready), .o_valid(o_valid), .o_data(o_data)
    );

    // reset always starts the clearing pass
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_ready)
        else $error("ready right after reset");

    // a clear command holds off the next word
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.cmd == shg_pkg::CMD_CLEAR) |=> !o_ready)
        else $error("ready during clear pass");

    // overflow only on an insert acknowledge
    a_ovf_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.overflow) |-> (o_data.last && !o_data.has_neighbor))
        else $error("overflow on a non-insert word");

    // a neighbor word means a query is still running
    a_neigh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.has_neighbor) |-> (!o_ready && !o_data.last))
        else $error("neighbor word while idle");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for spatial_hash_grid_neighbor_table
// Drives insert/query/clear words through the valid/ready input, predicts
// untyped output words from a behavioral copy of the hash table, and compares
// them in order. Covers several cell/table size settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] ADDR_CELL_SIZE  = 3'd0;
    localparam logic [2:0] ADDR_TABLE_SIZE = 3'd4;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         WDOG_LIMIT      = 20000;
    localparam int         HOLD_CYCLES     = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    shg_pkg::t_in_word    i_data = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    shg_pkg::t_out_word   o_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    spatial_hash_grid_neighbor_table dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the hash table and registers
    logic [shg_pkg::CS_W-1:0]    cell_size_q;
    logic [shg_pkg::TS_W-1:0]    tbl_size_q;
    logic [shg_pkg::FILL_W-1:0]  shadow_fill [shg_pkg::MAX_BUCKETS];
    logic [shg_pkg::ID_BITS-1:0] shadow_ids [shg_pkg::ENT_DEPTH];
    shg_pkg::t_out_word          expected_words [$];

    int errors = 0;
    int words_in = 0, words_out = 0, neigh_seen = 0, ovf_seen = 0;
    int send_pct = 0, recv_pct = 0;
    int hold_req = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // append one expected word at the tail
    function automatic void queue_word(input shg_pkg::t_out_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // floor(pos / cs), zero size taken as one
    function automatic logic [31:0] cell_of(input logic signed [31:0] pos,
                                            input logic [shg_pkg::CS_W-1:0] cs);
        longint p, d, q;
        p = pos;
        d = (cs == 0) ? 1 : longint'(cs);
        q = p / d;
        if ((p % d) != 0 && p < 0) q = q - 1;
        return q[31:0];
    endfunction

    function automatic logic [shg_pkg::BKT_W-1:0] bucket_of(input logic [31:0] cx,
                                                            input logic [31:0] cy,
                                                            input logic [31:0] cz);
        logic [31:0] h;
        logic [63:0] u;
        logic [63:0] t;
        h = shg_pkg::HASH_KX * cx + shg_pkg::HASH_KY * cy + shg_pkg::HASH_KZ * cz;
        u = {{32{h[31]}}, h};
        t = (tbl_size_q == 0) ? 64'd1 :
            (tbl_size_q > shg_pkg::MAX_BUCKETS) ? 64'(shg_pkg::MAX_BUCKETS)
                                                : 64'(tbl_size_q);
        return shg_pkg::BKT_W'(u % t);
    endfunction

    // update the shadow table and queue the words this input should produce
    task automatic predict_words(input shg_pkg::t_in_word w);
        logic [31:0]               cx, cy, cz;
        logic [shg_pkg::BKT_W-1:0] b;
        shg_pkg::t_out_word        r;
        cx = cell_of(w.pos_x, cell_size_q);
        cy = cell_of(w.pos_y, cell_size_q);
        cz = cell_of(w.pos_z, cell_size_q);
        r = '0;
        r.last = 1'b1;
        if (w.cmd == shg_pkg::CMD_INSERT) begin
            b = bucket_of(cx, cy, cz);
            r.bucket = b;
            if (shadow_fill[b] >= shg_pkg::BUCKET_CAPACITY) begin
                r.overflow = 1'b1;
            end else begin
                shadow_ids[b * shg_pkg::BUCKET_CAPACITY + shadow_fill[b]] = w.particle_id;
                shadow_fill[b] = shadow_fill[b] + 1'b1;
            end
        end else if (w.cmd == shg_pkg::CMD_QUERY) begin
            for (int i = -1; i <= 1; i++)
                for (int j = -1; j <= 1; j++)
                    for (int k = -1; k <= 1; k++) begin
                        shg_pkg::t_out_word n;
                        b = bucket_of(cx + 32'(i), cy + 32'(j), cz + 32'(k));
                        for (int e = 0; e < shadow_fill[b] && e < shg_pkg::BUCKET_CAPACITY;
                             e++) begin
                            n = '0;
                            n.bucket = b;
                            n.neighbor_id = shadow_ids[b * shg_pkg::BUCKET_CAPACITY + e];
                            n.has_neighbor = 1'b1;
                            queue_word(n);
                        end
                    end
        end else if (w.cmd == shg_pkg::CMD_CLEAR) begin
            foreach (shadow_fill[i]) shadow_fill[i] = '0;
        end
        queue_word(r);
    endtask

    // present one word; the expectation is either typed in or predicted
    task automatic send_word(input shg_pkg::t_in_word w, input bit typed,
                             input shg_pkg::t_out_word exp_w);
        int dummy;
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
        end
        @(posedge i_clk);
        words_in++;
        if (typed) begin
            dummy = expected_words.size();
            predict_words(w);
            while (expected_words.size() > dummy) void'(expected_words.pop_back());
            queue_word(exp_w);
        end else begin
            predict_words(w);
        end
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        i_valid <= 1'b0;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CELL_SIZE) cell_size_q = val[shg_pkg::CS_W-1:0];
        else tbl_size_q = val[shg_pkg::TS_W-1:0];
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_words.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    // random word, mostly near a few cells so queries find neighbors
    function automatic shg_pkg::t_in_word random_word();
        shg_pkg::t_in_word w;
        longint            cs;
        int                sel;
        cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        sel = $urandom_range(0, 99);
        w.cmd = (sel < 48) ? shg_pkg::CMD_INSERT : (sel < 88) ? shg_pkg::CMD_QUERY :
                (sel < 94) ? shg_pkg::CMD_CLEAR : CMD_UNUSED;
        w.particle_id = 16'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            w.pos_x = $urandom;
            w.pos_y = $urandom;
            w.pos_z = $urandom;
        end else begin
            w.pos_x = 32'(($urandom_range(0, 4) - 2) * cs + $urandom_range(0, 1000) % cs);
            w.pos_y = 32'(($urandom_range(0, 4) - 2) * cs + $urandom_range(0, 1000) % cs);
            w.pos_z = 32'(($urandom_range(0, 4) - 2) * cs + $urandom_range(0, 1000) % cs);
        end
        return w;
    endfunction

    // output side: random stalls, long hold-off on request, in-order compare
    initial begin : rx
        int hold_left;
        shg_pkg::t_out_word e;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (o_valid && i_ready) begin
                words_out++;
                if (o_data.has_neighbor) neigh_seen++;
                if (o_data.overflow) ovf_seen++;
                if (expected_words.size() == 0) begin
                    report($sformatf("unexpected word %h", o_data));
                end else begin
                    e = expected_words.pop_front();
                    if (o_data.bucket != e.bucket)
                        report($sformatf("bucket %0d, want %0d", o_data.bucket, e.bucket));
                    if (o_data.neighbor_id != e.neighbor_id)
                        report($sformatf("neighbor_id %h, want %h",
                                         o_data.neighbor_id, e.neighbor_id));
                    if (o_data.has_neighbor != e.has_neighbor)
                        report($sformatf("has_neighbor %b, want %b",
                                         o_data.has_neighbor, e.has_neighbor));
                    if (o_data.overflow != e.overflow)
                        report($sformatf("overflow %b, want %b", o_data.overflow, e.overflow));
                    if (o_data.last != e.last)
                        report($sformatf("last %b, want %b", o_data.last, e.last));
                end
            end
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("Watchdog expired with %0d words pending", expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    typedef struct {
        shg_pkg::t_in_word  w;
        bit                 typed;
        shg_pkg::t_out_word exp_w;
    } t_row;

    localparam shg_pkg::t_out_word ACK    = '{bucket: '0, neighbor_id: '0,
                                              has_neighbor: 1'b0, overflow: 1'b0,
                                              last: 1'b1};
    localparam shg_pkg::t_out_word OVF_B0 = '{bucket: '0, neighbor_id: '0,
                                              has_neighbor: 1'b0, overflow: 1'b1,
                                              last: 1'b1};

    t_row dir_rows [] = '{
        '{'{shg_pkg::CMD_QUERY,  32'sd0, 32'sd0, 32'sd0, 16'd0},       1'b1, ACK},
        '{'{shg_pkg::CMD_INSERT, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF},    1'b1, ACK},
        '{'{shg_pkg::CMD_INSERT, 32'sd100, 32'sd5, 32'sd65535, 16'h0}, 1'b1, ACK},
        '{'{shg_pkg::CMD_INSERT, 32'sd0, 32'sd0, 32'sd0, 16'h1234},    1'b1, OVF_B0},
        '{'{shg_pkg::CMD_QUERY,  32'sd0, 32'sd0, 32'sd0, 16'hAAAA},    1'b0, ACK},
        '{'{shg_pkg::CMD_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h5555},
          1'b0, ACK},
        '{'{shg_pkg::CMD_INSERT, 32'h80000000, 32'h80000000, 32'h80000000, 16'hAAAA},
          1'b0, ACK},
        '{'{shg_pkg::CMD_INSERT, -32'sd1, 32'sd65536, -32'sd65537, 16'h0F0F}, 1'b0, ACK},
        '{'{shg_pkg::CMD_INSERT, 32'h80000000, 32'h7FFFFFFF, 32'sd0, 16'hF0F0}, 1'b0, ACK},
        '{'{shg_pkg::CMD_QUERY,  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0},
          1'b0, ACK},
        '{'{shg_pkg::CMD_QUERY,  32'h80000000, 32'h80000000, 32'h80000000, 16'd0},
          1'b0, ACK},
        '{'{shg_pkg::CMD_QUERY,  -32'sd1, 32'sd0, -32'sd1, 16'd0},     1'b0, ACK},
        '{'{CMD_UNUSED, 32'h7FFFFFFF, 32'sd0, 32'sd0, 16'hFFFF},       1'b1, ACK},
        '{'{shg_pkg::CMD_QUERY,  32'sd0, 32'sd0, 32'sd0, 16'd0},       1'b0, ACK},
        '{'{shg_pkg::CMD_CLEAR,  32'sd7, 32'sd8, 32'sd9, 16'h0001},    1'b1, ACK},
        '{'{shg_pkg::CMD_QUERY,  32'sd0, 32'sd0, 32'sd0, 16'd0},       1'b1, ACK}
    };

    // register settings per phase: cell size, table size
    logic [31:0] cs_set [7] = '{32'd65536, 32'd0, 32'd1, 32'd32768,
                                32'h7FFFFFFF, 32'd131072, 32'd65536};
    logic [31:0] ts_set [7] = '{32'd1024, 32'd7, 32'd1, 32'd0,
                                32'd2047, 32'd13, 32'd1024};

    initial begin : main
        cell_size_q = shg_pkg::CELL_SIZE_RST;
        tbl_size_q  = shg_pkg::TABLE_SIZE_RST;
        foreach (shadow_fill[i]) shadow_fill[i] = '0;
        foreach (shadow_ids[i]) shadow_ids[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset settings
        foreach (dir_rows[r]) send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].exp_w);
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            reg_write(ADDR_CELL_SIZE, cs_set[ph]);
            reg_write(ADDR_TABLE_SIZE, ts_set[ph]);
            send_pct = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 10 : 0;
            recv_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 10 : 0;
            // long output hold-off so the block backs up into its input
            if (ph == 0) begin
                hold_req = HOLD_CYCLES;
                for (int n = 0; n < 8; n++) begin
                    shg_pkg::t_in_word w;
                    w = random_word();
                    w.cmd = shg_pkg::CMD_INSERT;
                    send_word(w, 1'b0, ACK);
                end
            end
            for (int n = 0; n < 70; n++) begin
                send_word(random_word(), 1'b0, ACK);
                // occasional pause until everything has drained
                if (n == 35) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    wait (expected_words.size() == 0);
                    @(posedge i_clk);
                end
            end
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        $display("Sent %0d words at reset settings and over 7 register phases; received %0d",
                 words_in, words_out);
        $display("Neighbor hits: %0d, overflow acks: %0d", neigh_seen, ovf_seen);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
